FILE: rtl/two_level_page_table_engine_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_UNIT_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TLPT_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define TLPT_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

FILE: rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

   localparam int NumTables  = 16;
   localparam int SlotW      = (NumTables > 1) ? $clog2(NumTables) : 1;
   localparam int CountW     = $clog2(NumTables + 1);
   localparam int DirEntries = 1024;
   localparam int DirW       = 10;
   localparam int TblW       = 10;
   localparam int StoreDepth = NumTables * DirEntries;
   localparam int StoreAw    = SlotW + TblW;

   localparam logic [1:0] CMD_MAP    = 2'd0;
   localparam logic [1:0] CMD_UNMAP  = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIR,
      ST_CLEAR,
      ST_TABLE,
      ST_RESULT,
      ST_INIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request
      logic init_step;   // clear one directory entry
      logic claim;       // claim slot, set directory entry
      logic clear_step;  // zero one table entry
      logic table_write; // write page entry
      logic table_zero;  // write zero entry (unmap)
      logic table_read;  // issue table read
      logic make_rsp;    // form response
      logic fail;        // report no free slot
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       dir_present;
      logic       slot_free;
      logic       count_last;
   } sts_type;

endpackage

FILE: rtl/tlpt_datapath.sv
// ----------------------------------------------------------------------------
// tlpt_datapath
// Directory, table store, slot counter and response register.
// ----------------------------------------------------------------------------
module tlpt_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_virt_addr,
   input  logic [31:0]        req_phys_addr_in,
   input  logic [11:0]        req_entry_flags,
   input  tlpt_pkg::ctl_type  ctl,
   output tlpt_pkg::sts_type  sts,
   output logic               rsp_status,
   output logic               rsp_mapped,
   output logic [31:0]        rsp_phys_addr_out
);
   import tlpt_pkg::*;

   logic [1:0]        cmd_ff;
   logic [31:0]       va_ff;
   logic [31:0]       pa_ff;
   logic [11:0]       flags_ff;
   logic [CountW-1:0] used_ff;
   logic [TblW-1:0]   cnt_ff;
   logic [SlotW:0]    dir_q_ff;
   logic [31:0]       tbl_q_ff;
   logic              st_ff;
   logic              mp_ff;
   logic [31:0]       ph_ff;

   logic [SlotW:0]    dir_mem [DirEntries];
   logic [31:0]       tbl_mem [StoreDepth];

   logic [DirW-1:0]   dir_idx;
   logic [SlotW-1:0]  slot;
   logic [StoreAw-1:0] waddr;

   assign dir_idx = ctl.init_step ? cnt_ff : va_ff[31:22];
   assign slot    = ctl.claim ? used_ff[SlotW-1:0] : dir_q_ff[SlotW-1:0];
   assign waddr   = ctl.clear_step ? {dir_q_ff[SlotW-1:0], cnt_ff}
                                   : {slot, va_ff[21:12]};

   // capture request
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_cmd;
         va_ff    <= req_virt_addr;
         pa_ff    <= req_phys_addr_in;
         flags_ff <= req_entry_flags;
      end
   end

   // advance sweep counter, count claimed slots
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (ctl.claim) used_ff <= used_ff + CountW'(1);
         if (ctl.init_step || ctl.clear_step) cnt_ff <= cnt_ff + TblW'(1);
      end
   end

   // directory: read, claim or clear
   always_ff @(posedge clock) begin
      if (ctl.init_step)
         dir_mem[dir_idx] <= '0;
      else if (ctl.claim)
         dir_mem[dir_idx] <= {1'b1, used_ff[SlotW-1:0]};
      if (ctl.claim)
         dir_q_ff <= {1'b1, used_ff[SlotW-1:0]};
      else if (ctl.load)
         dir_q_ff <= dir_mem[req_virt_addr[31:22]];
   end

   // table store: at most one write and one read per cycle
   always_ff @(posedge clock) begin
      if (ctl.clear_step || ctl.table_zero)
         tbl_mem[waddr] <= '0;
      else if (ctl.table_write)
         tbl_mem[waddr] <= {pa_ff[31:12], flags_ff};
      if (ctl.table_read)
         tbl_q_ff <= tbl_mem[waddr];
   end

   // form response
   always_ff @(posedge clock) begin
      if (ctl.make_rsp) begin
         st_ff <= ctl.fail;
         if (cmd_ff == CMD_LOOKUP && dir_q_ff[SlotW] && tbl_q_ff[0]) begin
            mp_ff <= 1'b1;
            ph_ff <= {tbl_q_ff[31:12], va_ff[11:0]};
         end else begin
            mp_ff <= 1'b0;
            ph_ff <= '0;
         end
      end
   end

   assign sts.cmd         = cmd_ff;
   assign sts.dir_present = dir_q_ff[SlotW];
   assign sts.slot_free   = (used_ff < CountW'(NumTables));
   assign sts.count_last  = (cnt_ff == '1);

   assign rsp_status        = st_ff;
   assign rsp_mapped        = mp_ff;
   assign rsp_phys_addr_out = ph_ff;

endmodule

FILE: rtl/tlpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer: directory init, directory read, table clear and access.
// ----------------------------------------------------------------------------
module tlpt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  tlpt_pkg::sts_type sts,
   output tlpt_pkg::ctl_type ctl
);
   import tlpt_pkg::*;

   state_type state_ff, state_in;
   logic      fail_ff, fail_in;
   logic      valid_ff, valid_in;
   logic      rsp_free;

   assign rsp_free = !valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      fail_in  = fail_ff;
      case (state_ff)
         ST_INIT:   if (sts.count_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_DIR;
         ST_DIR: begin
            fail_in  = 1'b0;
            state_in = ST_TABLE;
            if (sts.cmd == CMD_MAP && !sts.dir_present) begin
               if (sts.slot_free) state_in = ST_CLEAR;
               else begin
                  fail_in  = 1'b1;
                  state_in = ST_RESULT;
               end
            end
         end
         ST_CLEAR:  if (sts.count_last) state_in = ST_TABLE;
         ST_TABLE:  state_in = ST_RESULT;
         ST_RESULT: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl           = '0;
      req_stall     = 1'b1;
      ctl.fail      = fail_ff;
      case (state_ff)
         ST_INIT:  ctl.init_step = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         ST_DIR:
            ctl.claim = (sts.cmd == CMD_MAP) && !sts.dir_present && sts.slot_free;
         ST_CLEAR: ctl.clear_step = 1'b1;
         ST_TABLE: begin
            ctl.table_write = (sts.cmd == CMD_MAP);
            ctl.table_zero  = (sts.cmd == CMD_UNMAP) && sts.dir_present;
            ctl.table_read  = 1'b1;
         end
         ST_RESULT: ctl.make_rsp = rsp_free;
         default: ;
      endcase
   end

   // hold response valid until taken
   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (ctl.make_rsp) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         fail_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

FILE: rtl/two_level_page_table_engine_unit.sv
// An accepted request runs through states DIR, TABLE and RESULT before rsp_valid for
// lookup, unmap, unused codes and map to a present table; a map with no free slot
// skips TABLE, and a map that claims a new table slot clears it in CLEAR first.
// One request at a time: req_stall is high from acceptance until the engine is back
// in IDLE, after the response has been formed (RESULT waits while a beat is stalled).
// Reset: synchronous; an init pass then clears the directory, req_stall high until done.
// ----------------------------------------------------------------------------
// two_level_page_table_engine_unit
// Top level: controller plus datapath of the page table engine.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr_in,
   input  logic [11:0] req_entry_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic        rsp_mapped,
   output logic [31:0] rsp_phys_addr_out
);
   import tlpt_pkg::*;

   ctl_type ctl;
   sts_type sts;

   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   tlpt_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_virt_addr     (req_virt_addr),
      .req_phys_addr_in  (req_phys_addr_in),
      .req_entry_flags   (req_entry_flags),
      .ctl               (ctl),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_mapped        (rsp_mapped),
      .rsp_phys_addr_out (rsp_phys_addr_out)
   );

endmodule

FILE: rtl/tlpt_checker.sv
// ----------------------------------------------------------------------------
// tlpt_checker
// Port-level checks of the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_level_page_table_engine_unit_assert.svh"

module tlpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic        rsp_mapped,
   input logic [31:0] rsp_phys_addr_out
);
   // a stalled beat stays valid with a stable address
   `TLPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_phys_addr_out), "stalled response beat changed")
   // a failed map never reports a translation
   `TLPT_ASSERT_IMPL(a_fail_unmapped, clock, reset, rsp_valid && rsp_status,
      !rsp_mapped, "failed map reports mapped")
   // unmapped result carries a zero address
   `TLPT_ASSERT_IMPL(a_zero_addr, clock, reset, rsp_valid && !rsp_mapped,
      rsp_phys_addr_out == 32'd0, "unmapped result has nonzero address")
   // a request taken is not answered in the next cycle
   `TLPT_ASSERT_NEXT(a_no_early, clock, reset, req_valid && !req_stall && !rsp_valid,
      !rsp_valid, "response too early")

endmodule

bind two_level_page_table_engine_unit tlpt_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_mapped        (rsp_mapped),
   .rsp_phys_addr_out (rsp_phys_addr_out)
);
